### hdl/bbd_pkg.sv
// Shared types and constants for the RGGB bilinear demosaic core.
// No dependencies; every other file in hdl/ but bbd_ram imports this package.
package bbd_pkg;

    localparam int MaxWidth    = 2048;
    localparam int SampleBits  = 8;
    localparam int HeightLimit = 2048;
    localparam int MinDim      = 2;
    localparam int CfgW        = 12;
    localparam int PosW        = 12;
    localparam int LineAw      = $clog2(MaxWidth);

    localparam logic [CfgW-1:0] WidthReset  = CfgW'(640);
    localparam logic [CfgW-1:0] HeightReset = CfgW'(480);

    typedef logic [SampleBits-1:0] t_sample;
    typedef logic [8:0][SampleBits-1:0] t_win;

    typedef enum logic [0:0] {
        OP_SAMPLE = 1'b0,
        OP_FLUSH  = 1'b1
    } t_op;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    // Colour of a site, coded as {row parity, column parity}
    typedef enum logic [1:0] {
        CFA_RED     = 2'b00,
        CFA_GREEN_R = 2'b01,
        CFA_GREEN_B = 2'b10,
        CFA_BLUE    = 2'b11
    } t_cfa;

    typedef struct packed {
        logic emit;
        logic fend;
        t_cfa cfa;
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
    } t_site;

endpackage

### hdl/bbd_in_if.sv
// Raw sample channel: valid/ready handshake with operation and sample payload.
// Depends on bbd_pkg.
interface bbd_in_if;
    import bbd_pkg::*;

    logic    valid;
    logic    ready;
    t_op     operation;
    t_sample raw_sample;

    modport source (output valid, output operation, output raw_sample, input ready);
    modport sink   (input valid, input operation, input raw_sample, output ready);
endinterface

### hdl/bbd_out_if.sv
// RGB pixel channel: valid/ready handshake with colour and frame end payload.
// Depends on bbd_pkg.
interface bbd_out_if;
    import bbd_pkg::*;

    logic    valid;
    logic    ready;
    t_sample red;
    t_sample green;
    t_sample blue;
    logic    frame_end;

    modport source (output valid, output red, output green, output blue,
                    output frame_end, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input frame_end, output ready);
endinterface

### hdl/bayer_bilinear_demosaic_core.sv
// RGGB bilinear demosaic core. A registered pixel leaves after the transaction that
// completes its 3x3 neighbourhood (W+1 samples after its own site, W = frame width).
// Throughput: one transaction per cycle, set by the single line RAM read and write port
// per column and the per-cycle window shift; stalls on the output propagate back.
// Reset (synchronous, active low) clears positions, window and valids; frame width and
// height return to 640 and 480. Line buffers are not cleared; no warm-up pass.
module bayer_bilinear_demosaic_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    bbd_in_if.sink                   i_raw,
    bbd_out_if.source                o_rgb,
    input  logic                     i_cfg_we,
    input  bbd_pkg::t_reg_idx        i_cfg_index,
    input  logic [bbd_pkg::CfgW-1:0] i_cfg_data
);
    import bbd_pkg::*;

    logic              accept, take, item_in;
    t_site             seq_site;
    t_sample           seq_sample;
    logic [LineAw-1:0] seq_column;
    t_win              win;

    // Stage A: line RAM read in flight
    logic              r_a_valid;
    t_site             r_a_site;
    t_sample           r_a_sample;
    logic [LineAw-1:0] r_a_column;
    // Stage B: window holds the site's neighbourhood
    logic              r_b_valid;
    t_site             r_b_site;

    logic can_c, b_done, can_b, fire_b, can_a, load_c;

    assign b_done = !r_b_site.emit || can_c;
    assign can_b  = !r_b_valid || b_done;
    assign fire_b = r_a_valid && can_b;
    assign can_a  = !r_a_valid || fire_b;
    assign load_c = r_b_valid && r_b_site.emit && can_c;

    assign i_raw.ready = can_a;
    assign accept      = i_raw.valid && can_a;
    assign item_in     = accept && take;

    bbd_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_op        (i_raw.operation),
        .i_sample    (i_raw.raw_sample),
        .o_take      (take),
        .o_site      (seq_site),
        .o_sample    (seq_sample),
        .o_column    (seq_column)
    );

    bbd_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_read   (item_in),
        .i_raddr  (seq_column),
        .i_shift  (fire_b),
        .i_waddr  (r_a_column),
        .i_sample (r_a_sample),
        .o_win    (win)
    );

    bbd_interp u_interp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load_c),
        .i_win      (win),
        .i_site     (r_b_site),
        .o_rgb      (o_rgb),
        .o_can_load (can_c)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (item_in) begin
                r_a_valid <= 1'b1;
            end else if (fire_b) begin
                r_a_valid <= 1'b0;
            end
            if (fire_b) begin
                r_b_valid <= 1'b1;
            end else if (r_b_valid && b_done) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (item_in) begin
            r_a_site   <= seq_site;
            r_a_sample <= seq_sample;
            r_a_column <= seq_column;
        end
        if (fire_b) begin
            r_b_site <= r_a_site;
        end
    end

    a_b_holds_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && r_b_site.emit && !can_c |=> r_b_valid && $stable(r_b_site))
        else $error("window stage lost its site while the output was stalled");

    a_a_holds_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !can_b |=> r_a_valid && $stable(r_a_column) && $stable(r_a_sample))
        else $error("read stage lost its transaction while blocked");

    a_item_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        item_in |=> r_a_valid)
        else $error("accepted transaction did not enter the read stage");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rgb.valid)
        else $error("output valid after reset");
endmodule

### hdl/bbd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### hdl/bbd_seq.sv
// Frame geometry registers and raster position counters for input and output.
// Decides per transaction whether it enters the pipeline and tags the site.
// Depends on bbd_pkg.
module bbd_seq (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  bbd_pkg::t_reg_idx        i_cfg_index,
    input  logic [bbd_pkg::CfgW-1:0] i_cfg_data,
    input  logic                     i_accept,
    input  bbd_pkg::t_op             i_op,
    input  bbd_pkg::t_sample         i_sample,
    output logic                     o_take,
    output bbd_pkg::t_site           o_site,
    output bbd_pkg::t_sample         o_sample,
    output logic [bbd_pkg::LineAw-1:0] o_column
);
    import bbd_pkg::*;

    function automatic logic [CfgW-1:0] clamp_dim(logic [CfgW-1:0] v, logic [CfgW-1:0] hi);
        if (v < CfgW'(MinDim)) begin
            return CfgW'(MinDim);
        end else if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    logic [CfgW-1:0]   r_width, r_height;
    logic [LineAw-1:0] r_in_col, r_out_col;
    logic [PosW-1:0]   r_in_row, r_out_row;
    logic [LineAw-1:0] n_in_col, n_out_col;
    logic [PosW-1:0]   n_in_row, n_out_row;

    logic            in_frame;
    logic            emit;
    logic            fend;
    logic [CfgW-1:0] in_col_inc;
    logic [CfgW-1:0] out_col_inc;
    logic [PosW-1:0] out_row_inc;

    assign in_frame    = r_in_row < PosW'(r_height);
    assign in_col_inc  = CfgW'(r_in_col) + CfgW'(1);
    assign out_col_inc = CfgW'(r_out_col) + CfgW'(1);
    assign out_row_inc = r_out_row + PosW'(1);

    assign emit = (r_in_row >= PosW'(2)) || ((r_in_row == PosW'(1)) && (r_in_col != '0));
    assign fend = (out_row_inc >= PosW'(r_height)) && (out_col_inc >= r_width);

    // Flush ticks count only once the whole frame is in
    assign o_take   = !(in_frame && (i_op == OP_FLUSH));
    assign o_sample = in_frame ? i_sample : '0;
    assign o_column = r_in_col;

    always_comb begin
        o_site.emit     = emit;
        o_site.fend     = fend;
        o_site.cfa      = t_cfa'({r_out_row[0], r_out_col[0]});
        o_site.top_ok   = r_out_row != '0;
        o_site.bot_ok   = out_row_inc < PosW'(r_height);
        o_site.left_ok  = r_out_col != '0;
        o_site.right_ok = out_col_inc < r_width;
    end

    always_comb begin
        n_in_col  = in_col_inc[LineAw-1:0];
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (in_col_inc >= r_width) begin
            n_in_col = '0;
            n_in_row = r_in_row + PosW'(1);
        end
        if (emit) begin
            if (fend) begin
                // Last pixel out: start the next frame
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else if (out_col_inc >= r_width) begin
                n_out_col = '0;
                n_out_row = out_row_inc;
            end else begin
                n_out_col = out_col_inc[LineAw-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= WidthReset;
            r_height  <= HeightReset;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FRAME_WIDTH:  r_width  <= clamp_dim(i_cfg_data, CfgW'(MaxWidth));
                REG_FRAME_HEIGHT: r_height <= clamp_dim(i_cfg_data, CfgW'(HeightLimit));
                default: ;
            endcase
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (i_accept && o_take) begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end
endmodule

### hdl/bbd_window.sv
// Two line buffers, packed in one RAM word per column, and the 3x3 sample window.
// Depends on bbd_pkg and bbd_ram.
module bbd_window (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_read,
    input  logic [bbd_pkg::LineAw-1:0] i_raddr,
    input  logic                       i_shift,
    input  logic [bbd_pkg::LineAw-1:0] i_waddr,
    input  bbd_pkg::t_sample           i_sample,
    output bbd_pkg::t_win              o_win
);
    import bbd_pkg::*;

    logic [2*SampleBits-1:0] line_rd;
    t_sample                 top, mid;
    t_win                    r_win, n_win;

    // Word holds {upper line, middle line}; the column moves up one line on write
    bbd_ram #(
        .WIDTH (2*SampleBits),
        .DEPTH (MaxWidth)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (i_shift),
        .i_waddr (i_waddr),
        .i_wdata ({mid, i_sample}),
        .i_re    (i_read),
        .i_raddr (i_raddr),
        .o_rdata (line_rd)
    );

    assign top = line_rd[2*SampleBits-1:SampleBits];
    assign mid = line_rd[SampleBits-1:0];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_win[k*3+0] = r_win[k*3+1];
            n_win[k*3+1] = r_win[k*3+2];
        end
        n_win[2] = top;
        n_win[5] = mid;
        n_win[8] = i_sample;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (i_shift) begin
            r_win <= n_win;
        end
    end

    assign o_win = r_win;
endmodule

### hdl/bbd_interp.sv
// Neighbour means over the 3x3 window and the registered RGB output stage.
// Depends on bbd_pkg and bbd_out_if.
module bbd_interp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  bbd_pkg::t_win  i_win,
    input  bbd_pkg::t_site i_site,
    bbd_out_if.source      o_rgb,
    output logic           o_can_load
);
    import bbd_pkg::*;

    localparam int SumW     = SampleBits + 2;
    localparam int DivShift = SampleBits + 4;
    localparam int ProdW    = SumW + DivShift;
    localparam int Recip3   = (2 ** DivShift) / 3 + 1;

    function automatic logic [SumW-1:0] pick(t_sample v, logic en);
        return en ? SumW'(v) : '0;
    endfunction

    // Counts of one, two or four
    function automatic t_sample mean_pow2(logic [SumW-1:0] sum, logic [2:0] cnt);
        t_sample m;
        case (cnt)
            3'd1:    m = sum[SampleBits-1:0];
            3'd2:    m = sum[SampleBits:1];
            3'd4:    m = sum[SampleBits+1:2];
            default: m = '0;
        endcase
        return m;
    endfunction

    logic [SumW-1:0]  cross_sum, diag_sum, horiz_sum, vert_sum;
    logic [2:0]       cross_cnt, diag_cnt, horiz_cnt, vert_cnt;
    logic [ProdW-1:0] cross_prod;
    t_sample          cross_mean, diag_mean, horiz_mean, vert_mean, own;
    t_sample          n_red, n_green, n_blue;

    logic    r_valid;
    t_sample r_red, r_green, r_blue;
    logic    r_fend;

    logic top, bot, left, right;
    assign top   = i_site.top_ok;
    assign bot   = i_site.bot_ok;
    assign left  = i_site.left_ok;
    assign right = i_site.right_ok;

    assign own = i_win[4];

    assign cross_sum = pick(i_win[5], right) + pick(i_win[3], left)
                     + pick(i_win[7], bot) + pick(i_win[1], top);
    assign cross_cnt = 3'(right) + 3'(left) + 3'(bot) + 3'(top);

    assign diag_sum = pick(i_win[0], top && left) + pick(i_win[2], top && right)
                    + pick(i_win[6], bot && left) + pick(i_win[8], bot && right);
    assign diag_cnt = 3'(top && left) + 3'(top && right) + 3'(bot && left) + 3'(bot && right);

    assign horiz_sum = pick(i_win[3], left) + pick(i_win[5], right);
    assign horiz_cnt = 3'(left) + 3'(right);
    assign vert_sum  = pick(i_win[1], top) + pick(i_win[7], bot);
    assign vert_cnt  = 3'(top) + 3'(bot);

    // Divide by three through a scaled reciprocal; exact over the sum range
    assign cross_prod = ProdW'(cross_sum) * ProdW'(Recip3);
    assign cross_mean = (cross_cnt == 3'd3) ? cross_prod[DivShift +: SampleBits]
                                            : mean_pow2(cross_sum, cross_cnt);
    assign diag_mean  = mean_pow2(diag_sum, diag_cnt);
    assign horiz_mean = mean_pow2(horiz_sum, horiz_cnt);
    assign vert_mean  = mean_pow2(vert_sum, vert_cnt);

    always_comb begin
        unique case (i_site.cfa)
            CFA_RED: begin
                n_red   = own;
                n_green = cross_mean;
                n_blue  = diag_mean;
            end
            CFA_BLUE: begin
                n_red   = diag_mean;
                n_green = cross_mean;
                n_blue  = own;
            end
            CFA_GREEN_R: begin
                n_red   = horiz_mean;
                n_green = own;
                n_blue  = vert_mean;
            end
            CFA_GREEN_B: begin
                n_red   = vert_mean;
                n_green = own;
                n_blue  = horiz_mean;
            end
            default: begin
                n_red   = '0;
                n_green = '0;
                n_blue  = '0;
            end
        endcase
    end

    assign o_can_load = !r_valid || o_rgb.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_rgb.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
            r_fend  <= i_site.fend;
        end
    end

    assign o_rgb.valid     = r_valid;
    assign o_rgb.red       = r_red;
    assign o_rgb.green     = r_green;
    assign o_rgb.blue      = r_blue;
    assign o_rgb.frame_end = r_fend;
endmodule

### dv/bayer_bilinear_demosaic_core_test.sv
// Self-checking testbench for the RGGB bilinear demosaic core: a directed table, then random
// frames under three back-pressure regimes, each pixel checked by a predictor or a table entry.
// Depends on bbd_pkg, bbd_in_if, bbd_out_if and bayer_bilinear_demosaic_core from hdl/.
module bayer_bilinear_demosaic_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bbd_pkg::*;

    localparam int QuietLimit = 3000;   // well above the receiver's long hold
    localparam int DrainWait  = 8;      // margin for the read, window and output stages to drain
    localparam int PhaseItems = 70;

    typedef enum logic [1:0] {NB_CROSS, NB_DIAG, NB_HORIZ, NB_VERT} t_nb;
    typedef enum logic [1:0] {ROW_ITEM, ROW_CFG} t_row_kind;
    typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_PIXEL} t_exp_kind;

    typedef struct packed {
        t_sample red;
        t_sample green;
        t_sample blue;
        logic    frame_end;
    } t_pixel;

    typedef struct packed {
        t_row_kind       kind;
        t_reg_idx        idx;
        logic [CfgW-1:0] data;
        t_op             op;
        t_sample         smp;
        t_exp_kind       ek;
        t_pixel          px;
    } t_row;

    localparam t_pixel PIX_NONE      = '0;
    localparam t_pixel PIX_WHITE     = {8'hFF, 8'hFF, 8'hFF, 1'b0};
    localparam t_pixel PIX_WHITE_END = {8'hFF, 8'hFF, 8'hFF, 1'b1};
    localparam t_pixel PIX_BLACK     = {8'h00, 8'h00, 8'h00, 1'b0};
    localparam t_pixel PIX_BLACK_END = {8'h00, 8'h00, 8'h00, 1'b1};

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            i_cfg_we;
    t_reg_idx        i_cfg_index;
    logic [CfgW-1:0] i_cfg_data;

    bbd_in_if  raw_ch();
    bbd_out_if rgb_ch();

    bayer_bilinear_demosaic_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_raw      (raw_ch),
        .o_rgb      (rgb_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // Predictor state: frame geometry, line stores, 3x3 window, raster positions
    int unsigned fw = 640;
    int unsigned fh = 480;
    t_sample     upper_ln [MaxWidth];
    t_sample     middle_ln[MaxWidth];
    t_sample     win[9] = '{default: '0};
    int unsigned in_c = 0, in_r = 0, out_c = 0, out_r = 0;

    t_pixel pending_pixels[$];
    t_row   stim_tab[$];
    t_pixel want;
    int     mismatches   = 0;
    int     pixels_rx    = 0;
    int     items_sent   = 0;
    int     quiet_cycles = 0;
    int     snd_idle_pct = 27;
    int     rcv_idle_pct = 50;
    bit     frame_done;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_sample nb_mean(input t_nb kind);
        int          dr, dc, r, c, n;
        int unsigned sum, cnt;
        sum = 0;
        cnt = 0;
        n = (kind == NB_CROSS || kind == NB_DIAG) ? 4 : 2;
        for (int i = 0; i < n; i++) begin
            case (kind)
                NB_CROSS: begin
                    dr = (i < 2) ? 0 : ((i == 2) ? 1 : -1);
                    dc = (i == 0) ? 1 : ((i == 1) ? -1 : 0);
                end
                NB_DIAG: begin
                    dr = (i < 2) ? -1 : 1;
                    dc = (i % 2 == 1) ? 1 : -1;
                end
                NB_HORIZ: begin
                    dr = 0;
                    dc = (i == 0) ? -1 : 1;
                end
                default: begin
                    dr = (i == 0) ? -1 : 1;
                    dc = 0;
                end
            endcase
            r = int'(out_r) + dr;
            c = int'(out_c) + dc;
            // only in-frame neighbours count towards the mean
            if (r >= 0 && r < int'(fh) && c >= 0 && c < int'(fw)) begin
                sum += win[(1 + dr) * 3 + 1 + dc];
                cnt++;
            end
        end
        return (cnt == 0) ? t_sample'(0) : t_sample'(sum / cnt);
    endfunction

    function automatic bit demosaic_step(input t_op op, input t_sample smp,
                                         output t_pixel px);
        t_sample top, mid, own;
        bit      emit;
        px = PIX_NONE;
        if (in_r < fh) begin
            if (op == OP_FLUSH) return 1'b0;
        end else begin
            smp = '0;
        end
        top = upper_ln[in_c];
        mid = middle_ln[in_c];
        upper_ln[in_c]  = mid;
        middle_ln[in_c] = smp;
        for (int k = 0; k < 3; k++) begin
            win[k * 3]     = win[k * 3 + 1];
            win[k * 3 + 1] = win[k * 3 + 2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = smp;
        emit = (in_r >= 2) || (in_r == 1 && in_c >= 1);
        in_c++;
        if (in_c >= fw) begin
            in_c = 0;
            in_r++;
        end
        if (!emit) return 1'b0;
        own = win[4];
        case (t_cfa'({out_r[0], out_c[0]}))
            CFA_RED: begin
                px.red   = own;
                px.green = nb_mean(NB_CROSS);
                px.blue  = nb_mean(NB_DIAG);
            end
            CFA_BLUE: begin
                px.blue  = own;
                px.green = nb_mean(NB_CROSS);
                px.red   = nb_mean(NB_DIAG);
            end
            CFA_GREEN_R: begin
                px.green = own;
                px.red   = nb_mean(NB_HORIZ);
                px.blue  = nb_mean(NB_VERT);
            end
            default: begin
                px.green = own;
                px.blue  = nb_mean(NB_HORIZ);
                px.red   = nb_mean(NB_VERT);
            end
        endcase
        if (out_r + 1 >= fh && out_c + 1 >= fw) begin
            px.frame_end = 1'b1;
            in_c  = 0;
            in_r  = 0;
            out_c = 0;
            out_r = 0;
        end else begin
            out_c++;
            if (out_c >= fw) begin
                out_c = 0;
                out_r++;
            end
        end
        return 1'b1;
    endfunction

    function automatic void cfg_apply(input t_reg_idx idx, input logic [CfgW-1:0] val);
        int unsigned v;
        v = val;
        if (v < MinDim) v = MinDim;
        if (idx == REG_FRAME_WIDTH) begin
            if (v > MaxWidth) v = MaxWidth;
            fw = v;
        end else begin
            if (v > HeightLimit) v = HeightLimit;
            fh = v;
        end
        // any register write restarts the raster
        in_c  = 0;
        in_r  = 0;
        out_c = 0;
        out_r = 0;
    endfunction

    // Enter and leave at a falling edge.
    task automatic send_item(input t_op op, input t_sample smp, input t_exp_kind ek,
                             input t_pixel px);
        t_pixel guess;
        bit     got;
        while ($urandom_range(99) < snd_idle_pct) begin
            raw_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        raw_ch.valid      <= 1'b1;
        raw_ch.operation  <= op;
        raw_ch.raw_sample <= smp;
        @(posedge i_clk);
        while (raw_ch.ready !== 1'b1) @(posedge i_clk);
        got = demosaic_step(op, smp, guess);
        frame_done = got && guess.frame_end;
        case (ek)
            EXP_MODEL: if (got) pending_pixels.push_back(guess);
            EXP_PIXEL: pending_pixels.push_back(px);
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Drop valid and wait for the pipeline to empty.
    task automatic settle();
        raw_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending_pixels.size() != 0) @(negedge i_clk);
        repeat (DrainWait) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CfgW-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_apply(idx, val);
        @(negedge i_clk);
    endtask

    task automatic set_frame(input logic [CfgW-1:0] w, input logic [CfgW-1:0] h);
        settle();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    // Feed one frame, with stray flushes inside and stray samples in the tail,
    // until the frame completes or the item limit is hit.
    task automatic run_frame(input int limit);
        int      sent;
        t_op     op;
        t_sample smp;
        sent = 0;
        frame_done = 1'b0;
        while (!frame_done && sent < limit) begin
            case ($urandom_range(9))
                0: smp = '0;
                1: smp = '1;
                default: smp = t_sample'($urandom);
            endcase
            if (in_r < fh) op = ($urandom_range(99) < 4) ? OP_FLUSH : OP_SAMPLE;
            else op = ($urandom_range(99) < 20) ? OP_SAMPLE : OP_FLUSH;
            if (op == OP_SAMPLE || in_r >= fh) items_sent++;
            send_item(op, smp, EXP_MODEL, PIX_NONE);
            sent++;
        end
    endtask

    task automatic random_phase(input int budget);
        int          first, nf, left;
        int unsigned w, h;
        first = items_sent;
        while (items_sent - first < budget) begin
            w = ($urandom_range(3) == 0) ? $urandom_range(40, 2) : $urandom_range(9, 2);
            h = $urandom_range(6, 2);
            // now and then an undersized value, which saturates to the minimum
            set_frame(CfgW'(($urandom_range(7) == 0) ? $urandom_range(1) : w),
                      CfgW'(($urandom_range(7) == 0) ? $urandom_range(1) : h));
            nf = $urandom_range(3, 1);
            for (int f = 0; f < nf; f++) begin
                left = budget - (items_sent - first);
                if (left <= 0) break;
                // abandon the last frame part-way at times; the next write restarts it
                if (f == nf - 1 && $urandom_range(4) == 0)
                    run_frame(int'($urandom_range(fw * fh)) % left);
                else
                    run_frame(left);
            end
        end
    endtask

    task automatic tab_item(input t_op op, input t_sample smp, input t_exp_kind ek,
                            input t_pixel px);
        t_row row;
        row      = '0;
        row.kind = ROW_ITEM;
        row.op   = op;
        row.smp  = smp;
        row.ek   = ek;
        row.px   = px;
        stim_tab.push_back(row);
    endtask

    task automatic tab_cfg(input t_reg_idx idx, input logic [CfgW-1:0] val);
        t_row row;
        row      = '0;
        row.kind = ROW_CFG;
        row.idx  = idx;
        row.data = val;
        stim_tab.push_back(row);
    endtask

    // Pixel checker
    always @(posedge i_clk) begin
        if (i_rst_n && rgb_ch.valid && rgb_ch.ready) begin
            pixels_rx++;
            if (pending_pixels.size() == 0) begin
                $error("pixel with nothing expected: r=%0d g=%0d b=%0d end=%0b",
                       rgb_ch.red, rgb_ch.green, rgb_ch.blue, rgb_ch.frame_end);
                mismatches++;
            end else begin
                want = pending_pixels.pop_front();
                if (rgb_ch.red !== want.red) begin
                    $error("red: expected %0d, got %0d", want.red, rgb_ch.red);
                    mismatches++;
                end
                if (rgb_ch.green !== want.green) begin
                    $error("green: expected %0d, got %0d", want.green, rgb_ch.green);
                    mismatches++;
                end
                if (rgb_ch.blue !== want.blue) begin
                    $error("blue: expected %0d, got %0d", want.blue, rgb_ch.blue);
                    mismatches++;
                end
                if (rgb_ch.frame_end !== want.frame_end) begin
                    $error("frame_end: expected %0b, got %0b", want.frame_end,
                           rgb_ch.frame_end);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((raw_ch.valid && raw_ch.ready) || (rgb_ch.valid && rgb_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QuietLimit) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Pixel sink: random ready, plus a long hold every so often to back the core up
    initial begin : pixel_sink
        int hold_left;
        int hold_at;
        hold_left = 0;
        hold_at   = 20;
        rgb_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && pixels_rx >= hold_at) begin
                hold_left = 300;
                hold_at += 2500;
            end
            if (hold_left > 0) begin
                rgb_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                rgb_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    initial begin : stimulus
        t_row row;
        i_rst_n           <= 1'b0;
        raw_ch.valid      <= 1'b0;
        raw_ch.operation  <= OP_SAMPLE;
        raw_ch.raw_sample <= '0;
        i_cfg_we          <= 1'b0;
        i_cfg_index       <= REG_FRAME_WIDTH;
        i_cfg_data        <= '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset geometry: just past one 640-wide row, enough for a few pixels
        repeat (645) send_item(OP_SAMPLE, t_sample'($urandom), EXP_MODEL, PIX_NONE);

        // Out-of-range writes saturate to a 2x2 frame
        tab_cfg(REG_FRAME_WIDTH, 12'd0);
        tab_cfg(REG_FRAME_HEIGHT, 12'd1);
        // Full-scale frame, drained by flush ticks
        tab_item(OP_SAMPLE, 8'hFF, EXP_NONE,  PIX_NONE);
        tab_item(OP_SAMPLE, 8'hFF, EXP_NONE,  PIX_NONE);
        tab_item(OP_SAMPLE, 8'hFF, EXP_NONE,  PIX_NONE);
        tab_item(OP_SAMPLE, 8'hFF, EXP_PIXEL, PIX_WHITE);
        tab_item(OP_FLUSH,  8'h00, EXP_PIXEL, PIX_WHITE);
        tab_item(OP_FLUSH,  8'h00, EXP_PIXEL, PIX_WHITE);
        tab_item(OP_FLUSH,  8'h00, EXP_PIXEL, PIX_WHITE_END);
        // Zero frame: flush mid-frame is ignored, samples past the end act as flushes
        tab_item(OP_SAMPLE, 8'h00, EXP_NONE,  PIX_NONE);
        tab_item(OP_SAMPLE, 8'h00, EXP_NONE,  PIX_NONE);
        tab_item(OP_FLUSH,  8'hFF, EXP_NONE,  PIX_NONE);
        tab_item(OP_SAMPLE, 8'h00, EXP_NONE,  PIX_NONE);
        tab_item(OP_SAMPLE, 8'h00, EXP_PIXEL, PIX_BLACK);
        tab_item(OP_SAMPLE, 8'hFF, EXP_PIXEL, PIX_BLACK);
        tab_item(OP_SAMPLE, 8'hFF, EXP_PIXEL, PIX_BLACK);
        tab_item(OP_SAMPLE, 8'hFF, EXP_PIXEL, PIX_BLACK_END);
        // Odd width, every site colour with partial neighbourhoods
        tab_cfg(REG_FRAME_WIDTH, 12'd3);
        tab_cfg(REG_FRAME_HEIGHT, 12'd2);
        tab_item(OP_SAMPLE, 8'h00, EXP_MODEL, PIX_NONE);
        tab_item(OP_SAMPLE, 8'hFF, EXP_MODEL, PIX_NONE);
        tab_item(OP_SAMPLE, 8'h55, EXP_MODEL, PIX_NONE);
        tab_item(OP_SAMPLE, 8'hAA, EXP_MODEL, PIX_NONE);
        tab_item(OP_SAMPLE, 8'h0F, EXP_MODEL, PIX_NONE);
        tab_item(OP_SAMPLE, 8'hF0, EXP_MODEL, PIX_NONE);
        tab_item(OP_FLUSH,  8'h00, EXP_MODEL, PIX_NONE);
        tab_item(OP_FLUSH,  8'h00, EXP_MODEL, PIX_NONE);
        tab_item(OP_FLUSH,  8'h00, EXP_MODEL, PIX_NONE);
        tab_item(OP_FLUSH,  8'h00, EXP_MODEL, PIX_NONE);

        while (stim_tab.size() != 0) begin
            row = stim_tab.pop_front();
            if (row.kind == ROW_CFG) begin
                settle();
                write_reg(row.idx, row.data);
            end else begin
                send_item(row.op, row.smp, row.ek, row.px);
            end
        end

        random_phase(PhaseItems);

        settle();
        snd_idle_pct <= 50;
        rcv_idle_pct <= 27;
        random_phase(PhaseItems);

        settle();
        snd_idle_pct <= 0;
        rcv_idle_pct <= 0;
        // Widest and tallest frames via saturating writes; run only their first rows
        set_frame(12'hFFF, 12'd2);
        run_frame(16);
        set_frame(12'd2, 12'hFFF);
        run_frame(64);
        random_phase(PhaseItems);

        settle();
        repeat (16) @(negedge i_clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

### bayer_bilinear_demosaic_core.f
hdl/bbd_pkg.sv
hdl/bbd_in_if.sv
hdl/bbd_out_if.sv
hdl/bbd_ram.sv
hdl/bbd_seq.sv
hdl/bbd_window.sv
hdl/bbd_interp.sv
hdl/bayer_bilinear_demosaic_core.sv
dv/bayer_bilinear_demosaic_core_test.sv
